// ===== sv/leb_pkg.sv =====
// Shared types and operation codes for the line edit buffer.
// No dependencies; used by leb_cell and line_edit_buffer.
`default_nettype none

package leb_pkg;

  localparam logic [2:0] OP_INSERT    = 3'd0;
  localparam logic [2:0] OP_BACKSPACE = 3'd1;
  localparam logic [2:0] OP_DELETE    = 3'd2;
  localparam logic [2:0] OP_CLEAR     = 3'd3;
  localparam logic [2:0] OP_READ      = 3'd4;

  localparam int unsigned READ_SPAN  = 256;
  localparam int unsigned GROUP_SIZE = 16;

  typedef struct packed {
    logic       ins;
    logic       rem;
    logic       clr;
    logic [7:0] ch;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/leb_cell.sv =====
// One character cell of the line: holds a byte and trades it with its neighbors.
// Depends on leb_pkg for the control struct.
`default_nettype none

module leb_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned PW    = 9
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire leb_pkg::cell_ctrl_t ctrl,
  input  wire logic [PW-1:0]       pos,
  input  wire logic [7:0]          left_data,
  input  wire logic [7:0]          right_data,
  input  wire logic [7:0]          read_pos,
  output logic      [7:0]          data,
  output logic      [7:0]          read_data
);

  localparam logic [PW-1:0] MY_POS = PW'(INDEX);

  logic hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      data <= 8'h00;
    end else if (ctrl.clr) begin
      data <= 8'h00;
    end else if (ctrl.ins) begin
      if (MY_POS == pos) begin
        data <= ctrl.ch;
      end else if (MY_POS > pos) begin
        data <= left_data;
      end
    end else if (ctrl.rem) begin
      if (MY_POS >= pos) begin
        data <= right_data;
      end
    end
  end

  assign hit       = (INDEX < leb_pkg::READ_SPAN) && (read_pos == 8'(INDEX));
  assign read_data = hit ? data : 8'h00;

endmodule

`default_nettype wire

// ===== sv/line_edit_buffer.sv =====
// Top level of the line edit buffer: operation control, cursor and length,
// a row of leb_cell instances and a two-stage read reduction. Depends on leb_pkg.
//
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready  | op, char_in, read_pos
// out     | output    | out_valid / out_ready| status, char_out, line_length, cursor_pos
//
// Insert, backspace, delete, clear and refused words complete in the cycle they are taken: every cell
// shifts or loads in the same edge and the result register is written with it.
// A read passes the registered group OR stage and then the char_out register, in state S_READ.
// Reset clears every cell, the length and the cursor.
// A new word is taken when the block is not reading and the result register is
// empty or being emptied in that cycle; a stalled output holds the input off.
`default_nettype none

module line_edit_buffer #(
  parameter int unsigned LINE_CAPACITY = 256
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] op,
  input  wire logic [7:0] char_in,
  input  wire logic [7:0] read_pos,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            status,
  output logic [7:0]      char_out,
  output logic [8:0]      line_length,
  output logic [8:0]      cursor_pos
);

  localparam int unsigned LW = $clog2(LINE_CAPACITY + 1);
  localparam int unsigned RCELLS = (LINE_CAPACITY < leb_pkg::READ_SPAN) ?
                                   LINE_CAPACITY : leb_pkg::READ_SPAN;
  localparam int unsigned NG = (RCELLS + leb_pkg::GROUP_SIZE - 1) / leb_pkg::GROUP_SIZE;
  localparam logic [LW-1:0] CAP = LW'(LINE_CAPACITY);

  typedef enum logic {S_IDLE, S_READ} state_t;

  state_t              state;
  logic [LW-1:0]       length;
  logic [LW-1:0]       cursor;
  logic [LW-1:0]       length_next;
  logic [LW-1:0]       cursor_next;
  logic [LW-1:0]       pos;
  logic                status_next;
  logic                accept;
  logic                read_bad;
  logic                result_load;
  leb_pkg::cell_ctrl_t ctrl;
  logic [7:0]          cell_data [LINE_CAPACITY];
  logic [7:0]          cell_rd   [RCELLS];
  logic [7:0]          group_or      [NG];
  logic [7:0]          group_or_next [NG];
  logic [7:0]          read_byte;

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign read_bad = ({1'b0, read_pos} >= 9'(RCELLS)) && (LINE_CAPACITY < leb_pkg::READ_SPAN);
  assign result_load = (state == S_READ) ||
                       (accept && !(op == leb_pkg::OP_READ && !read_bad));

  always_comb begin
    length_next = length;
    cursor_next = cursor;
    pos         = cursor;
    status_next = 1'b0;
    ctrl        = '{ins: 1'b0, rem: 1'b0, clr: 1'b0, ch: char_in};
    case (op)
      leb_pkg::OP_INSERT: begin
        if (length == CAP) begin
          status_next = 1'b1;
        end else begin
          ctrl.ins    = accept;
          length_next = length + 1'b1;
          cursor_next = cursor + 1'b1;
        end
      end
      leb_pkg::OP_BACKSPACE: begin
        if (cursor == '0) begin
          status_next = 1'b1;
        end else begin
          ctrl.rem    = accept;
          pos         = cursor - 1'b1;
          length_next = length - 1'b1;
          cursor_next = cursor - 1'b1;
        end
      end
      leb_pkg::OP_DELETE: begin
        if (cursor >= length) begin
          status_next = 1'b1;
        end else begin
          ctrl.rem    = accept;
          length_next = length - 1'b1;
        end
      end
      leb_pkg::OP_CLEAR: begin
        ctrl.clr    = accept;
        length_next = '0;
        cursor_next = '0;
      end
      leb_pkg::OP_READ: begin
        status_next = read_bad;
      end
      default: begin
        status_next = 1'b1;
      end
    endcase
  end

  for (genvar i = 0; i < LINE_CAPACITY; i++) begin : g_cell
    logic [7:0] left_in;
    logic [7:0] right_in;
    if (i == 0) begin : g_first
      assign left_in = 8'h00;
    end else begin : g_mid_l
      assign left_in = cell_data[i-1];
    end
    if (i == LINE_CAPACITY - 1) begin : g_last
      assign right_in = 8'h00;
    end else begin : g_mid_r
      assign right_in = cell_data[i+1];
    end
    if (i < RCELLS) begin : g_rd
      leb_cell #(.INDEX(i), .PW(LW)) u_cell (
        .clk(clk), .rst(rst), .ctrl(ctrl), .pos(pos),
        .left_data(left_in), .right_data(right_in), .read_pos(read_pos),
        .data(cell_data[i]), .read_data(cell_rd[i])
      );
    end else begin : g_nord
      leb_cell #(.INDEX(i), .PW(LW)) u_cell (
        .clk(clk), .rst(rst), .ctrl(ctrl), .pos(pos),
        .left_data(left_in), .right_data(right_in), .read_pos(read_pos),
        .data(cell_data[i]), .read_data()
      );
    end
  end

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      group_or_next[g] = 8'h00;
      for (int j = 0; j < leb_pkg::GROUP_SIZE; j++) begin
        if (g * leb_pkg::GROUP_SIZE + j < RCELLS) begin
          group_or_next[g] = group_or_next[g] | cell_rd[g * leb_pkg::GROUP_SIZE + j];
        end
      end
    end
  end

  always_comb begin
    read_byte = 8'h00;
    for (int g = 0; g < NG; g++) begin
      read_byte = read_byte | group_or[g];
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < NG; g++) begin
      group_or[g] <= group_or_next[g];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      length    <= '0;
      cursor    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (result_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            length      <= length_next;
            cursor      <= cursor_next;
            status      <= status_next;
            char_out    <= 8'h00;
            line_length <= 9'(length_next);
            cursor_pos  <= 9'(cursor_next);
            if (op == leb_pkg::OP_READ && !read_bad) begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          char_out <= read_byte;
          state    <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_cursor_in_line: assert property (@(posedge clk) disable iff (rst)
    cursor <= length) else $error("cursor beyond end of line");

  a_length_in_cap: assert property (@(posedge clk) disable iff (rst)
    length <= CAP) else $error("length beyond capacity");

  a_read_no_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> !out_valid) else $error("result pending during read");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (accept && op == leb_pkg::OP_CLEAR) |=> (length == '0 && cursor == '0))
    else $error("clear left a nonempty line");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && op == leb_pkg::OP_INSERT && length != CAP) |=>
    (length == $past(length) + 1'b1)) else $error("insert did not grow the line");

endmodule

`default_nettype wire
